// File: design/command_route_table_with_timers_defines.svh
// assertion macros for the route table
`ifndef COMMAND_ROUTE_TABLE_WITH_TIMERS_DEFINES_SVH
`define COMMAND_ROUTE_TABLE_WITH_TIMERS_DEFINES_SVH

// implication checked every cycle outside reset
`define CRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication with the consequent checked in the next cycle
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/crt_pkg.sv
package crt_pkg;
    typedef enum logic [2:0] {
        FN_ADD_DEF = 3'd0,
        FN_ADD_CMD = 3'd1,
        FN_REM_DEF = 3'd2,
        FN_REM_CMD = 3'd3,
        FN_ROUTE   = 3'd4,
        FN_TICK    = 3'd5
    } t_func;

    localparam logic [2:0] KIND_DIRECT   = 3'd0;
    localparam logic [2:0] KIND_FALLBACK = 3'd1;
    localparam logic [2:0] KIND_NOROUTE  = 3'd2;
    localparam logic [2:0] KIND_DONE     = 3'd3;
    localparam logic [2:0] KIND_FULL     = 3'd4;

    localparam logic [15:0] CMD_DEFAULT = 16'hFFFF;

    // one classified operation between front and back
    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  device;
        logic [7:0]  inst;
        logic [15:0] command;
        logic [7:0]  handler;
        logic [30:0] period;
        logic [31:0] value;
    } t_op;

    // one result toward the ports
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  handler;
        logic [15:0] command;
        logic [31:0] param;
        logic        last;
    } t_res;
endpackage

// File: design/crt_front.sv
module crt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [2:0]     i_func,
    input  logic [7:0]     i_device,
    input  logic [7:0]     i_instance_req,
    input  logic [15:0]    i_command,
    input  logic [7:0]     i_handler_id,
    input  logic [30:0]    i_period,
    input  logic [31:0]    i_value,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output crt_pkg::t_op   o_op
);
    import crt_pkg::*;

    // two-entry queue of classified operations
    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op        w_op;

    always_comb begin
        w_op.func    = i_func;
        w_op.device  = i_device;
        w_op.inst    = i_instance_req;
        w_op.handler = i_handler_id;
        w_op.value   = i_value;
        w_op.command = i_command;
        w_op.period  = i_period;
        case (i_func)
            FN_ADD_DEF, FN_REM_DEF: begin
                w_op.command = CMD_DEFAULT;
                w_op.period  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_take) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_take) - 2'(i_pop);
        end
        if (i_take) r_q[r_wp] <= w_op;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_q[r_rp];
endmodule

// File: design/crt_back.sv
module crt_back #(
    parameter int ENTRIES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  crt_pkg::t_op  i_op,
    output logic          o_pop,
    output logic          o_idle,
    output logic          o_res_vld,
    output crt_pkg::t_res o_res,
    output logic          o_fin
);
    import crt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_REM, S_SCAN, S_TSEL, S_EMIT, S_FIN
    } t_state;

    t_state         r_state, n_state;
    logic [7:0]     r_dev [ENTRIES];
    logic [7:0]     r_ins [ENTRIES];
    logic [15:0]    r_cmd [ENTRIES];
    logic [7:0]     r_hnd [ENTRIES];
    logic [30:0]    r_per [ENTRIES];
    logic [31:0]    r_due [ENTRIES];
    logic [CW-1:0]  r_count, n_count;
    logic [31:0]    r_val, n_val;
    logic [CW-1:0]  r_i, n_i, r_k, n_k, r_t, n_t;
    logic [7:0]     r_rdev, n_rdev, r_rins, n_rins;
    logic [15:0]    r_rcmd, n_rcmd;
    logic           r_hit, n_hit, r_hfb, n_hfb, r_any, n_any, r_tick, n_tick;
    logic [7:0]     r_fbh, n_fbh;
    logic           r_res_vld, n_res_vld;
    t_res           r_res, n_res;
    logic           r_fin, n_fin;

    logic [IW-1:0]  w_i, w_k, w_t;
    logic           w_dimatch, w_cmatch, w_scan_end, w_due, w_tend;
    logic           w_full, w_add, w_mv, w_adv;
    logic [31:0]    w_diff;

    assign w_i = r_i[IW-1:0];
    assign w_k = r_k[IW-1:0];
    assign w_t = r_t[IW-1:0];
    assign w_dimatch  = (r_dev[w_i] == r_rdev) && (r_ins[w_i] == r_rins);
    assign w_cmatch   = w_dimatch && (r_cmd[w_i] == r_rcmd);
    assign w_scan_end = (r_i == r_count);
    assign w_diff     = r_val - r_due[w_t];
    assign w_due      = (r_per[w_t] != '0) && !w_diff[31];
    assign w_tend     = (r_t + 1'b1 == r_count);
    assign w_full     = (r_count == CW'(ENTRIES));

    // table write enables
    assign w_add = (r_state == S_IDLE) && i_valid && !w_full &&
                   (i_op.func inside {FN_ADD_DEF, FN_ADD_CMD});
    assign w_mv  = (r_state == S_REM) && !w_scan_end && !w_cmatch;
    assign w_adv = (r_state == S_TSEL) && w_due;

    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign o_idle    = (r_state == S_IDLE);
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;
    assign o_fin     = r_fin;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_val     = r_val;
        n_i       = r_i;
        n_k       = r_k;
        n_t       = r_t;
        n_rdev    = r_rdev;
        n_rins    = r_rins;
        n_rcmd    = r_rcmd;
        n_hit     = r_hit;
        n_hfb     = r_hfb;
        n_any     = r_any;
        n_tick    = r_tick;
        n_fbh     = r_fbh;
        n_res     = r_res;
        n_res_vld = 1'b0;
        n_fin     = 1'b0;
        case (r_state)
            S_IDLE: if (i_valid) begin
                n_val  = i_op.value;
                n_rdev = i_op.device;
                n_rins = i_op.inst;
                n_rcmd = i_op.command;
                n_i    = '0;
                n_k    = '0;
                n_t    = '0;
                n_hit  = 1'b0;
                n_hfb  = 1'b0;
                n_any  = 1'b0;
                n_tick = 1'b0;
                n_res  = '{kind: KIND_DONE, handler: '0, command: '0,
                           param: '0, last: 1'b0};
                case (t_func'(i_op.func))
                    FN_ADD_DEF, FN_ADD_CMD: begin
                        n_res_vld = 1'b1;
                        n_state   = S_FIN;
                        if (w_full) n_res.kind = KIND_FULL;
                        else n_count = r_count + 1'b1;
                    end
                    FN_REM_DEF, FN_REM_CMD: n_state = S_REM;
                    FN_ROUTE: n_state = S_SCAN;
                    FN_TICK: begin
                        n_tick = 1'b1;
                        if (r_count == '0) begin
                            n_res_vld = 1'b1;
                            n_state   = S_FIN;
                        end else begin
                            n_state = S_TSEL;
                        end
                    end
                    default: begin
                        n_res_vld = 1'b1;
                        n_state   = S_FIN;
                    end
                endcase
            end
            S_REM: begin
                // compact survivors one slot a cycle
                if (w_scan_end) begin
                    n_count   = r_k;
                    n_res_vld = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    if (!w_cmatch) n_k = r_k + 1'b1;
                    n_i = r_i + 1'b1;
                end
            end
            S_TSEL: begin
                // find the next due entry
                if (w_due) begin
                    n_rdev  = r_dev[w_t];
                    n_rins  = r_ins[w_t];
                    n_rcmd  = r_cmd[w_t];
                    n_i     = '0;
                    n_hit   = 1'b0;
                    n_hfb   = 1'b0;
                    n_any   = 1'b1;
                    n_state = S_SCAN;
                end else if (w_tend) begin
                    if (!r_any) begin
                        n_res_vld = 1'b1;
                        n_res     = '{kind: KIND_DONE, handler: '0, command: '0,
                                      param: '0, last: 1'b0};
                    end
                    n_state = S_FIN;
                end else begin
                    n_t = r_t + 1'b1;
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_EMIT;
                end else begin
                    if (w_dimatch) begin
                        n_fbh = r_hnd[w_i];
                        n_hfb = 1'b1;
                    end
                    if (w_cmatch) begin
                        n_hit     = 1'b1;
                        n_res_vld = 1'b1;
                        n_res     = '{kind: KIND_DIRECT, handler: r_hnd[w_i],
                                      command: r_rcmd, param: r_val, last: 1'b0};
                    end
                    n_i = r_i + 1'b1;
                end
            end
            S_EMIT: begin
                if (!r_hit) begin
                    n_res_vld = 1'b1;
                    n_res     = '{kind: r_hfb ? KIND_FALLBACK : KIND_NOROUTE,
                                  handler: r_hfb ? r_fbh : 8'd0,
                                  command: r_rcmd, param: r_val, last: 1'b0};
                end
                if (r_tick && !w_tend) begin
                    n_t     = r_t + 1'b1;
                    n_state = S_TSEL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // item complete, lets the output stage flag its final result
                n_fin   = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_res_vld <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_res_vld <= n_res_vld;
            r_fin     <= n_fin;
        end
        r_val  <= n_val;
        r_i    <= n_i;
        r_k    <= n_k;
        r_t    <= n_t;
        r_rdev <= n_rdev;
        r_rins <= n_rins;
        r_rcmd <= n_rcmd;
        r_hit  <= n_hit;
        r_hfb  <= n_hfb;
        r_any  <= n_any;
        r_tick <= n_tick;
        r_fbh  <= n_fbh;
        r_res  <= n_res;
    end

    // route table storage, slot 0 newest
    always_ff @(posedge i_clk) begin
        if (w_add) begin
            for (int j = ENTRIES - 1; j > 0; j--) begin
                r_dev[j] <= r_dev[j-1];
                r_ins[j] <= r_ins[j-1];
                r_cmd[j] <= r_cmd[j-1];
                r_hnd[j] <= r_hnd[j-1];
                r_per[j] <= r_per[j-1];
                r_due[j] <= r_due[j-1];
            end
            r_dev[0] <= i_op.device;
            r_ins[0] <= i_op.inst;
            r_cmd[0] <= i_op.command;
            r_hnd[0] <= i_op.handler;
            r_per[0] <= i_op.period;
            r_due[0] <= (i_op.period != '0) ? i_op.value + {1'b0, i_op.period} : '0;
        end else if (w_mv) begin
            r_dev[w_k] <= r_dev[w_i];
            r_ins[w_k] <= r_ins[w_i];
            r_cmd[w_k] <= r_cmd[w_i];
            r_hnd[w_k] <= r_hnd[w_i];
            r_per[w_k] <= r_per[w_i];
            r_due[w_k] <= r_due[w_i];
        end else if (w_adv) begin
            r_due[w_t] <= r_due[w_t] + {1'b0, r_per[w_t]};
        end
    end
endmodule

// File: design/crt_out.sv
module crt_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  crt_pkg::t_res i_res,
    input  logic          i_fin,
    output logic          o_vld,
    output crt_pkg::t_res o_res
);
    import crt_pkg::*;

    // each result waits here until the next one or the item end shows if it is last
    logic r_hv, r_ov, r_olast;
    t_res r_h, r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_hv && (i_vld || i_fin);
            if (i_vld) r_hv <= 1'b1;
            else if (i_fin) r_hv <= 1'b0;
        end
        if (i_vld) r_h <= i_res;
        if (r_hv && (i_vld || i_fin)) begin
            r_o     <= r_h;
            r_olast <= !i_vld;
        end
    end

    always_comb begin
        o_res      = r_o;
        o_res.last = r_olast;
    end

    assign o_vld = r_ov;
endmodule

// File: design/command_route_table_with_timers.sv
// route table with periodic timers, one transfer in flight at a time
// remove and route scan the whole table; tick steps through every entry and
// scans the table once per due entry; a new transfer is taken only after the
// final strobe of the one before; the back end scans the table serially,
// one slot per cycle
// reset: i_rst_n synchronous active low empties the table; results cannot be stalled
`include "command_route_table_with_timers_defines.svh"
module command_route_table_with_timers #(
    parameter int ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_device,
    input  logic [7:0]  i_instance_req,
    input  logic [15:0] i_command,
    input  logic [7:0]  i_handler_id,
    input  logic [30:0] i_period,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_out_handler,
    output logic [15:0] o_out_command,
    output logic [31:0] o_out_param,
    output logic        o_last
);
    import crt_pkg::*;

    logic  w_full, w_qv, w_pop, w_idle, w_bv, w_fin;
    t_op   w_op;
    t_res  w_br, w_res;
    logic  r_pend;

    // one item in flight: busy from transfer until its final result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else if (start && !busy) r_pend <= 1'b1;
        else if (o_strobe && o_last) r_pend <= 1'b0;
    end
    assign busy = r_pend;

    // front: capture and classify
    crt_front u_front (
        .i_clk, .i_rst_n,
        .i_take(start && !busy),
        .i_func, .i_device, .i_instance_req, .i_command, .i_handler_id,
        .i_period, .i_value,
        .i_pop(w_pop), .o_full(w_full), .o_valid(w_qv), .o_op(w_op)
    );

    // back: table walk and dispatch
    crt_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .i_op(w_op),
        .o_pop(w_pop), .o_idle(w_idle), .o_res_vld(w_bv), .o_res(w_br),
        .o_fin(w_fin)
    );

    // result staging marks the final result of each item
    crt_out u_out (
        .i_clk, .i_rst_n, .i_vld(w_bv), .i_res(w_br), .i_fin(w_fin),
        .o_vld(o_strobe), .o_res(w_res)
    );

    assign o_kind        = w_res.kind;
    assign o_out_handler = w_res.handler;
    assign o_out_command = w_res.command;
    assign o_out_param   = w_res.param;
    assign o_last        = w_res.last;

    `CRT_ASSERT_IMP(a_no_full, i_clk, i_rst_n, start && !busy, !w_full)
    `CRT_ASSERT_IMP(a_idle_done, i_clk, i_rst_n, !busy, w_idle && !w_qv)
    `CRT_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule
